/* rtl/dcbdl_pkg.sv */
package dcbdl_pkg;

  // Delay line geometry
  localparam int unsigned DELAY_DEPTH = 1024;
  localparam int unsigned DL_AW       = $clog2(DELAY_DEPTH);
  localparam int unsigned DL_CW       = $clog2(DELAY_DEPTH + 1);

  // Sample and coefficient widths
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned VOL_W    = 17;
  localparam int unsigned POLE_W   = 16;
  localparam int unsigned COEFF_W  = 17;
  localparam int unsigned TARGET_W = 18;
  localparam int unsigned DELAY_W  = 10;
  localparam int unsigned ENV_W    = 17;

  // Shared multiplier operand widths
  localparam int unsigned MUL_AW = SAMPLE_W;
  localparam int unsigned MUL_BW = 18;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

  // APB register file
  localparam int unsigned APB_AW  = 5;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned REG_IW  = 3;

  localparam logic [REG_IW-1:0] REG_VOLUME  = 3'd0;
  localparam logic [REG_IW-1:0] REG_DC_POLE = 3'd1;
  localparam logic [REG_IW-1:0] REG_ATTACK  = 3'd2;
  localparam logic [REG_IW-1:0] REG_RELEASE = 3'd3;
  localparam logic [REG_IW-1:0] REG_LIMIT   = 3'd4;
  localparam logic [REG_IW-1:0] REG_DELAY   = 3'd5;

  localparam logic [VOL_W-1:0]    RST_VOLUME  = 17'd58386;
  localparam logic [POLE_W-1:0]   RST_DC_POLE = 16'd65208;
  localparam logic [COEFF_W-1:0]  RST_ATTACK  = 17'd19661;
  localparam logic [COEFF_W-1:0]  RST_RELEASE = 17'd655;
  localparam logic [TARGET_W-1:0] RST_LIMIT   = 18'd39322;
  localparam logic [DELAY_W-1:0]  RST_DELAY   = 10'd100;

  // Unity in Q1.16
  localparam logic [ENV_W-1:0] ONE_Q16 = 17'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DCPOLE,
    ST_BLOCK,
    ST_ENV,
    ST_GAIN,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_SCALE,
    OP_DC,
    OP_ENV,
    OP_OUT
  } mul_op_e;

  typedef struct packed {
    logic    mul_en;
    mul_op_e op;
    logic    scaled_en;
    logic    block_en;
    logic    env_en;
    logic    out_load;
  } ctrl_t;

endpackage

/* rtl/dcbdl_mul.sv */
module dcbdl_mul (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [dcbdl_pkg::MUL_AW-1:0]  a_i,
  input  logic signed [dcbdl_pkg::MUL_BW-1:0]  b_i,
  output logic signed [dcbdl_pkg::MUL_PW-1:0]  prod_o
);
  import dcbdl_pkg::*;

  logic signed [MUL_PW-1:0] prod_d;
  logic signed [MUL_PW-1:0] prod_q;

  assign prod_d = MUL_PW'(a_i) * MUL_PW'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

/* rtl/dcbdl_dline.sv */
module dcbdl_dline (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    rd_en_i,
  input  logic        [dcbdl_pkg::DL_AW-1:0]      delay_i,
  input  logic                                    wr_en_i,
  input  logic signed [dcbdl_pkg::SAMPLE_W-1:0]   wr_data_i,
  output logic signed [dcbdl_pkg::SAMPLE_W-1:0]   rd_data_o
);
  import dcbdl_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DELAY_DEPTH];

  logic [DL_AW-1:0]           wr_idx_q, wr_idx_d;
  logic [DL_CW-1:0]           fill_q, fill_d;
  logic                       rd_hit_q, rd_hit_d;
  logic [DL_AW-1:0]           rd_addr;
  logic signed [SAMPLE_W-1:0] rd_data_q;

  // Read position trails the write position by the delay, wrapping at the depth
  always_comb begin
    if (wr_idx_q >= delay_i) begin
      rd_addr = wr_idx_q - delay_i;
    end else begin
      rd_addr = DL_AW'(DL_CW'(wr_idx_q) + DL_CW'(DELAY_DEPTH) - DL_CW'(delay_i));
    end
  end

  // Writes fill the line in order from zero, so entries at or past the fill
  // count have never been written and read as zero
  always_comb begin
    wr_idx_d = wr_idx_q;
    fill_d   = fill_q;
    rd_hit_d = rd_hit_q;
    if (rd_en_i) begin
      rd_hit_d = DL_CW'(rd_addr) < fill_q;
    end
    if (wr_en_i) begin
      wr_idx_d = (wr_idx_q == DL_AW'(DELAY_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
      if (fill_q != DL_CW'(DELAY_DEPTH)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      fill_q   <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      wr_idx_q <= wr_idx_d;
      fill_q   <= fill_d;
      rd_hit_q <= rd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_q] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign rd_data_o = rd_hit_q ? rd_data_q : '0;

endmodule

/* rtl/dcbdl_ctrl.sv */
module dcbdl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_busy_i,
  input  logic             out_ready_i,
  output logic             in_ready_o,
  output dcbdl_pkg::ctrl_t ctrl_o
);
  import dcbdl_pkg::*;

  state_e state_q, state_d;
  logic   out_free;

  assign out_free = !out_busy_i || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_DCPOLE;
      ST_DCPOLE: state_d = ST_BLOCK;
      ST_BLOCK:  state_d = ST_ENV;
      ST_ENV:    state_d = ST_GAIN;
      ST_GAIN:   state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    ctrl_o.op  = OP_SCALE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        ctrl_o.mul_en = in_valid_i;
        ctrl_o.op     = OP_SCALE;
      end
      ST_DCPOLE: begin
        ctrl_o.scaled_en = 1'b1;
        ctrl_o.mul_en    = 1'b1;
        ctrl_o.op        = OP_DC;
      end
      ST_BLOCK: begin
        ctrl_o.block_en = 1'b1;
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.op       = OP_ENV;
      end
      ST_ENV: begin
        ctrl_o.env_en = 1'b1;
      end
      ST_GAIN: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op     = OP_OUT;
      end
      ST_OUT: begin
        ctrl_o.out_load = out_free;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/dc_block_delay_limiter.sv */
// Channel    | Handshake                 | Payload
// -----------+---------------------------+------------------------------------
// mix in     | mix_valid_i / mix_ready_o | mix_sample_i (s32, Q15.16)
// result out | out_valid_o / out_ready_i | out_sample_o (s16, Q1.15), clipped_o
// config     | APB psel/penable/pwrite   | paddr (5b), pwdata/prdata (32b)
//
// Each accepted sample is worked through before the next is taken: four passes through
// the single shared 32x18 multiplier (volume, DC pole, envelope step, output
// gain) plus the envelope add and the output rounding step.
// Reset clears filter and envelope state at once; the delay line has no
// clearing pass, a fill count makes never-written entries read as zero.
// A result waiting in the output register does not stop the next sample from
// being accepted; only the final step holds until the output register is free.
module dc_block_delay_limiter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // sample input
  input  logic                                  mix_valid_i,
  output logic                                  mix_ready_o,
  input  logic signed [dcbdl_pkg::SAMPLE_W-1:0] mix_sample_i,
  // result output
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [dcbdl_pkg::OUT_W-1:0]    out_sample_o,
  output logic                                  clipped_o,
  // APB configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic        [dcbdl_pkg::APB_AW-1:0]   paddr,
  input  logic        [dcbdl_pkg::APB_DW-1:0]   pwdata,
  output logic        [dcbdl_pkg::APB_DW-1:0]   prdata,
  output logic                                  pready
);
  import dcbdl_pkg::*;

  localparam logic signed [35:0] S32_MAX = 36'sd2147483647;
  localparam logic signed [35:0] S32_MIN = -36'sd2147483648;
  localparam logic signed [MUL_PW-18:0] S16_MAX = 33'sd32767;
  localparam logic signed [MUL_PW-18:0] S16_MIN = -33'sd32768;

  // Round half up, then drop 16 fraction bits (arithmetic shift is floor)
  function automatic logic signed [MUL_PW-17:0] rnd16(input logic signed [MUL_PW-1:0] p);
    logic [MUL_PW-1:0] t;
    t = p + {{(MUL_PW-16){1'b0}}, 1'b1, 15'b0};
    return t[MUL_PW-1:16];
  endfunction

  // Same with 17 fraction bits, for the Q1.16 x Q15.16 -> Q1.15 product
  function automatic logic signed [MUL_PW-18:0] rnd17(input logic signed [MUL_PW-1:0] p);
    logic [MUL_PW-1:0] t;
    t = p + {{(MUL_PW-17){1'b0}}, 1'b1, 16'b0};
    return t[MUL_PW-1:17];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [35:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX[SAMPLE_W-1:0];
    end else if (v < S32_MIN) begin
      r = S32_MIN[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [VOL_W-1:0]    volume_gain_q;
  logic [POLE_W-1:0]   dc_pole_q;
  logic [COEFF_W-1:0]  attack_coeff_q;
  logic [COEFF_W-1:0]  release_coeff_q;
  logic [TARGET_W-1:0] limit_target_q;
  logic [DELAY_W-1:0]  delay_samples_q;
  logic                cfg_wr;
  logic [REG_IW-1:0]   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_gain_q   <= RST_VOLUME;
      dc_pole_q       <= RST_DC_POLE;
      attack_coeff_q  <= RST_ATTACK;
      release_coeff_q <= RST_RELEASE;
      limit_target_q  <= RST_LIMIT;
      delay_samples_q <= RST_DELAY;
    end else if (cfg_wr) begin
      // Unknown indexes drop the write
      unique case (cfg_idx)
        REG_VOLUME:  volume_gain_q   <= pwdata[VOL_W-1:0];
        REG_DC_POLE: dc_pole_q       <= pwdata[POLE_W-1:0];
        REG_ATTACK:  attack_coeff_q  <= pwdata[COEFF_W-1:0];
        REG_RELEASE: release_coeff_q <= pwdata[COEFF_W-1:0];
        REG_LIMIT:   limit_target_q  <= pwdata[TARGET_W-1:0];
        REG_DELAY:   delay_samples_q <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_VOLUME:  prdata = APB_DW'(volume_gain_q);
      REG_DC_POLE: prdata = APB_DW'(dc_pole_q);
      REG_ATTACK:  prdata = APB_DW'(attack_coeff_q);
      REG_RELEASE: prdata = APB_DW'(release_coeff_q);
      REG_LIMIT:   prdata = APB_DW'(limit_target_q);
      REG_DELAY:   prdata = APB_DW'(delay_samples_q);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  ctrl_t ctrl;
  logic  accept;
  logic  out_valid_q;

  dcbdl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mix_valid_i),
    .out_busy_i  (out_valid_q),
    .out_ready_i (out_ready_i),
    .in_ready_o  (mix_ready_o),
    .ctrl_o      (ctrl)
  );

  assign accept = mix_valid_i && mix_ready_o;

  // ---------------------------------------------------------------------------
  // Envelope setup, taken at acceptance from the settled envelope
  // ---------------------------------------------------------------------------
  logic [ENV_W-1:0]          gain_env_q, gain_env_d;
  logic [ENV_W-1:0]          target;
  logic [COEFF_W-1:0]        coeff_raw;
  logic signed [ENV_W:0]     diff_q;
  logic [COEFF_W-1:0]        coeff_q;

  always_comb begin
    // Clamp the target and the chosen coefficient to unity
    target    = (limit_target_q > TARGET_W'(ONE_Q16)) ? ONE_Q16 : limit_target_q[ENV_W-1:0];
    coeff_raw = (target < gain_env_q) ? attack_coeff_q : release_coeff_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      diff_q  <= $signed({1'b0, target}) - $signed({1'b0, gain_env_q});
      coeff_q <= (coeff_raw > COEFF_W'(ONE_Q16)) ? COEFF_W'(ONE_Q16) : coeff_raw;
    end
  end

  // ---------------------------------------------------------------------------
  // Delay line: read at acceptance, written with the blocker output
  // ---------------------------------------------------------------------------
  logic [DL_AW-1:0]           delay_cl;
  logic signed [SAMPLE_W-1:0] delayed;
  logic signed [SAMPLE_W-1:0] blocked;

  // Delays at or beyond the depth fall back to the longest one
  assign delay_cl = (32'(delay_samples_q) >= 32'(DELAY_DEPTH)) ? DL_AW'(DELAY_DEPTH - 1)
                                                               : DL_AW'(delay_samples_q);

  dcbdl_dline u_dline (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .delay_i   (delay_cl),
    .wr_en_i   (ctrl.block_en),
    .wr_data_i (blocked),
    .rd_data_o (delayed)
  );

  // ---------------------------------------------------------------------------
  // Shared multiplier and its operand select
  // ---------------------------------------------------------------------------
  logic signed [MUL_AW-1:0]   mul_a;
  logic signed [MUL_BW-1:0]   mul_b;
  logic signed [MUL_PW-1:0]   prod;
  // Blocker state, the previous output feeds the pole product
  logic signed [SAMPLE_W-1:0] scaled_q;
  logic signed [SAMPLE_W-1:0] dc_prev_in_q;
  logic signed [SAMPLE_W-1:0] dc_prev_out_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      OP_SCALE: begin
        mul_a = mix_sample_i;
        mul_b = $signed({1'b0, volume_gain_q});
      end
      OP_DC: begin
        mul_a = dc_prev_out_q;
        mul_b = $signed({2'b0, dc_pole_q});
      end
      OP_ENV: begin
        mul_a = MUL_AW'(diff_q);
        mul_b = $signed({1'b0, coeff_q});
      end
      OP_OUT: begin
        mul_a = delayed;
        mul_b = $signed({1'b0, gain_env_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  dcbdl_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // ---------------------------------------------------------------------------
  // DC blocker: y = x - x1 + R*y1, each step saturated to 32 bits
  // ---------------------------------------------------------------------------
  logic signed [35:0]         block_sum;

  assign block_sum = 36'(scaled_q) - 36'(dc_prev_in_q) + 36'(rnd16(prod));
  assign blocked   = sat32(block_sum);

  // Hold the scaled sample until the pole product is ready
  always_ff @(posedge clk_i) begin
    if (ctrl.scaled_en) begin
      scaled_q <= sat32(36'(rnd16(prod)));
    end
  end

  // Advance the envelope by the rounded coefficient step
  assign gain_env_d = ENV_W'(36'($signed({1'b0, gain_env_q})) + 36'(rnd16(prod)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_prev_in_q  <= '0;
      dc_prev_out_q <= '0;
      gain_env_q    <= '0;
    end else begin
      if (ctrl.block_en) begin
        dc_prev_in_q  <= scaled_q;
        dc_prev_out_q <= blocked;
      end
      if (ctrl.env_en) begin
        gain_env_q <= gain_env_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output rounding, saturation and output register
  // ---------------------------------------------------------------------------
  logic signed [MUL_PW-18:0] y_full;
  logic signed [OUT_W-1:0]   y_sat;
  logic                      y_clip;
  logic signed [OUT_W-1:0]   out_sample_q;
  logic                      clipped_q;

  assign y_full = rnd17(prod);

  always_comb begin
    if (y_full > S16_MAX) begin
      y_sat  = S16_MAX[OUT_W-1:0];
      y_clip = 1'b1;
    end else if (y_full < S16_MIN) begin
      y_sat  = S16_MIN[OUT_W-1:0];
      y_clip = 1'b1;
    end else begin
      y_sat  = y_full[OUT_W-1:0];
      y_clip = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_sample_q <= y_sat;
      clipped_q    <= y_clip;
    end
  end

  // Load only when the register is empty or being drained this cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign clipped_o    = clipped_q;

endmodule

/* rtl/dcbdl_checker.sv */
module dcbdl_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  mix_valid_i,
  input logic                                  mix_ready_o,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic signed [dcbdl_pkg::OUT_W-1:0]    out_sample_o,
  input logic                                  clipped_o
);
  import dcbdl_pkg::*;

  // Result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_sample_o) && $stable(clipped_o))
    else $error("output transaction dropped or changed while stalled");

  // The sequencer is busy after taking a sample
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_valid_i && mix_ready_o |=> !mix_ready_o ##1 !mix_ready_o ##1 !mix_ready_o)
    else $error("input taken again while a sample is in flight");

  // No result can appear within the first steps after an accept
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_valid_i && mix_ready_o |=> !$rose(out_valid_o) ##1 !$rose(out_valid_o))
    else $error("result produced too early");

  // A clipped result sits at full scale
  a_clip_full_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |-> (out_sample_o == 16'sh7fff || out_sample_o == 16'sh8000))
    else $error("clipped result not at full scale");

endmodule

bind dc_block_delay_limiter dcbdl_checker u_dcbdl_checker (.*);
